FILE: hdl/btu_pkg.sv
// shared command, mode and stop reason codes for the breakpoint table unit
package btu_pkg;

  localparam logic [2:0] CMD_SET      = 3'd0;
  localparam logic [2:0] CMD_CLEAR    = 3'd1;
  localparam logic [2:0] CMD_QUERY    = 3'd2;
  localparam logic [2:0] CMD_ARM_ALL  = 3'd3;
  localparam logic [2:0] CMD_SET_TEMP = 3'd4;
  localparam logic [2:0] CMD_INSTALL  = 3'd5;
  localparam logic [2:0] CMD_CHECK    = 3'd6;

  localparam logic [1:0] MODE_UNSET = 2'd0;
  localparam logic [1:0] MODE_SET   = 2'd1;
  localparam logic [1:0] MODE_GROUP = 2'd2;

  localparam logic [1:0] REASON_NONE    = 2'd0;
  localparam logic [1:0] REASON_BREAK   = 2'd1;
  localparam logic [1:0] REASON_STEPPED = 2'd2;
  localparam logic [1:0] REASON_EXITED  = 2'd3;

  localparam logic [15:0] TRAP_WORD = 16'h4afc;

  typedef struct packed {
    logic        we;
    logic [31:0] address;
    logic [15:0] saved_word;
    logic [15:0] hits;
    logic        we_address;
    logic        we_saved_word;
  } btu_wr_t;

endpackage

FILE: hdl/breakpoint_table_unit.sv
// breakpoint table unit top level: entry walk sequencer, entry memories, result word register
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------------
//  command  | start, busy, in_*                       | taken when start & !busy
//  result   | out_strobe, out_*                       | one strobe per word
//  config   | cfg_we, cfg_wdata                       | written when cfg_we
//
// every command runs from accept to the next possible accept through these states:
// the sequencer walks one slot per cycle through the entry memories (one read port,
// one registered read, so ST_LAST drains the last slot), then ST_TEMP handles the
// temporary entry, ST_STATUS the status, and ST_IDLE waits before start is taken again.
// busy is high from accept until the status word appears on the result ports.
// reset clears slot modes, address written flags, the temporary entry and exit_address.
// result words cannot be stalled; each word is shown for exactly one cycle.
module breakpoint_table_unit
  import btu_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_address,
  input  logic        in_address_ok,
  input  logic [15:0] in_hit_count,
  input  logic        in_group_mode,
  input  logic [15:0] in_saved_word,
  output logic        out_strobe,
  output logic        out_write_valid,
  output logic [31:0] out_write_address,
  output logic [15:0] out_write_data,
  output logic        out_ok,
  output logic [1:0]  out_stop_reason,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_TEMP,
    ST_STATUS
  } state_t;

  state_t      state_r, state_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic          p_vld_r, p_vld_nxt;
  logic [IW-1:0] p_idx_r, p_idx_nxt;

  logic [2:0]  cmd_r, cmd_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic        valid_r, valid_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        grp_r, grp_nxt;
  logic [15:0] word_r, word_nxt;

  logic          f1_r, f1_nxt;
  logic [IW-1:0] f1_idx_r, f1_idx_nxt;
  logic          f2_r, f2_nxt;
  logic [IW-1:0] f2_idx_r, f2_idx_nxt;
  logic          ok_r, ok_nxt;
  logic          slot_hit_r, slot_hit_nxt;
  logic          temp_hit_r, temp_hit_nxt;

  logic [31:0] exit_r, exit_nxt;
  logic [31:0] temp_addr_r, temp_addr_nxt;
  logic [15:0] temp_word_r, temp_word_nxt;
  logic        temp_armed_r, temp_armed_nxt;

  logic [1:0] mode_r [ENTRIES];
  logic [1:0] mode_nxt [ENTRIES];
  logic       written_r [ENTRIES];
  logic       written_nxt [ENTRIES];

  logic        o_strobe_r, o_strobe_nxt;
  logic        o_wv_r, o_wv_nxt;
  logic [31:0] o_wa_r, o_wa_nxt;
  logic [15:0] o_wd_r, o_wd_nxt;
  logic        o_ok_r, o_ok_nxt;
  logic [1:0]  o_reason_r, o_reason_nxt;
  logic        o_last_r, o_last_nxt;

  btu_wr_t       wr;
  logic [IW-1:0] waddr;
  logic [31:0]   addr_q;
  logic [15:0]   word_q;
  logic [15:0]   hits_q;

  logic [31:0] ent_addr;
  logic [1:0]  ent_mode;
  logic        ent_eq;
  logic        match;
  logic [15:0] hits_dec;
  logic [1:0]  new_mode;
  logic [IW-1:0] slot;

  btu_ram #(.DEPTH(ENTRIES), .WIDTH(32), .AW(IW)) u_addr_ram (
    .clk   (clk),
    .we    (wr.we && wr.we_address),
    .waddr (waddr),
    .wdata (wr.address),
    .raddr (rd_idx_r),
    .rdata (addr_q)
  );

  btu_ram #(.DEPTH(ENTRIES), .WIDTH(16), .AW(IW)) u_word_ram (
    .clk   (clk),
    .we    (wr.we && wr.we_saved_word),
    .waddr (waddr),
    .wdata (wr.saved_word),
    .raddr (rd_idx_r),
    .rdata (word_q)
  );

  btu_ram #(.DEPTH(ENTRIES), .WIDTH(16), .AW(IW)) u_hits_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (waddr),
    .wdata (wr.hits),
    .raddr (rd_idx_r),
    .rdata (hits_q)
  );

  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    p_vld_nxt      = (state_r == ST_SCAN);
    p_idx_nxt      = rd_idx_r;
    cmd_nxt        = cmd_r;
    addr_nxt       = addr_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    grp_nxt        = grp_r;
    word_nxt       = word_r;
    f1_nxt         = f1_r;
    f1_idx_nxt     = f1_idx_r;
    f2_nxt         = f2_r;
    f2_idx_nxt     = f2_idx_r;
    ok_nxt         = ok_r;
    slot_hit_nxt   = slot_hit_r;
    temp_hit_nxt   = temp_hit_r;
    exit_nxt       = cfg_we ? cfg_wdata : exit_r;
    temp_addr_nxt  = temp_addr_r;
    temp_word_nxt  = temp_word_r;
    temp_armed_nxt = temp_armed_r;
    mode_nxt       = mode_r;
    written_nxt    = written_r;
    o_strobe_nxt   = 1'b0;
    o_wv_nxt       = 1'b0;
    o_wa_nxt       = 32'd0;
    o_wd_nxt       = 16'd0;
    o_ok_nxt       = 1'b0;
    o_reason_nxt   = REASON_NONE;
    o_last_nxt     = 1'b0;
    wr             = '0;
    waddr          = p_idx_r;
    slot           = f1_r ? f1_idx_r : f2_idx_r;

    // processing stage for the slot read last cycle
    ent_addr = written_r[p_idx_r] ? addr_q : 32'd0;
    ent_mode = mode_r[p_idx_r];
    ent_eq   = (ent_addr == addr_r);
    hits_dec = hits_q - 16'd1;
    new_mode = ent_mode;
    if ((cmd_r == CMD_CLEAR) || (cmd_r == CMD_QUERY)) begin
      match = (ent_mode != MODE_UNSET) && ent_eq;
    end else begin
      match = ((ent_mode == MODE_UNSET) && (ent_addr == 32'd0)) || ent_eq;
    end

    if (p_vld_r) begin
      case (cmd_r) inside
        CMD_SET, CMD_CLEAR, CMD_QUERY: begin
          if (match && !f1_r) begin
            f1_nxt     = 1'b1;
            f1_idx_nxt = p_idx_r;
          end
          if ((cmd_r == CMD_SET) && (ent_mode == MODE_UNSET) && !f2_r) begin
            f2_nxt     = 1'b1;
            f2_idx_nxt = p_idx_r;
          end
        end
        CMD_ARM_ALL: begin
          if ((ent_mode == MODE_UNSET) && (ent_addr != 32'd0)) begin
            mode_nxt[p_idx_r] = MODE_SET;
            wr.we             = 1'b1;
            wr.hits           = 16'd1;
          end
        end
        CMD_INSTALL: begin
          if (ent_mode != MODE_UNSET) begin
            o_strobe_nxt = 1'b1;
            o_wv_nxt     = 1'b1;
            o_wa_nxt     = ent_addr;
            o_wd_nxt     = TRAP_WORD;
          end
        end
        CMD_CHECK: begin
          if (ent_mode != MODE_UNSET) begin
            o_strobe_nxt = 1'b1;
            o_wv_nxt     = 1'b1;
            o_wa_nxt     = ent_addr;
            o_wd_nxt     = word_q;
            if (ent_eq) begin
              slot_hit_nxt = 1'b1;
              wr.we        = 1'b1;
              wr.hits      = hits_dec;
              if (hits_dec == 16'd0) begin
                new_mode = MODE_UNSET;
              end
            end
            if (new_mode == MODE_GROUP) begin
              new_mode = MODE_UNSET;
            end
            mode_nxt[p_idx_r] = new_mode;
          end
        end
        default: begin
        end
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt      = in_cmd;
          addr_nxt     = in_address;
          valid_nxt    = in_address_ok && (in_address != 32'd0);
          cnt_nxt      = in_hit_count;
          grp_nxt      = in_group_mode;
          word_nxt     = in_saved_word;
          rd_idx_nxt   = '0;
          f1_nxt       = 1'b0;
          f2_nxt       = 1'b0;
          ok_nxt       = 1'b0;
          slot_hit_nxt = 1'b0;
          temp_hit_nxt = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx_r == LAST_IDX) begin
          state_nxt = ST_LAST;
        end else begin
          rd_idx_nxt = rd_idx_r + IW'(1);
        end
      end
      ST_LAST: begin
        state_nxt = ST_TEMP;
      end
      ST_TEMP: begin
        state_nxt = ST_STATUS;
        case (cmd_r)
          CMD_SET: begin
            if (valid_r && (f1_r || f2_r)) begin
              waddr            = slot;
              mode_nxt[slot]   = grp_r ? MODE_GROUP : MODE_SET;
              written_nxt[slot] = 1'b1;
              wr.we            = 1'b1;
              wr.we_address    = 1'b1;
              wr.we_saved_word = 1'b1;
              wr.address       = addr_r;
              wr.saved_word    = word_r;
              wr.hits          = cnt_r;
              ok_nxt           = 1'b1;
            end
          end
          CMD_CLEAR: begin
            if (f1_r) begin
              mode_nxt[f1_idx_r] = MODE_UNSET;
              ok_nxt             = 1'b1;
            end
          end
          CMD_QUERY: begin
            ok_nxt = valid_r && f1_r;
          end
          CMD_SET_TEMP: begin
            temp_armed_nxt = 1'b1;
            temp_addr_nxt  = addr_r;
            temp_word_nxt  = word_r;
          end
          CMD_INSTALL: begin
            if (temp_armed_r) begin
              o_strobe_nxt = 1'b1;
              o_wv_nxt     = 1'b1;
              o_wa_nxt     = temp_addr_r;
              o_wd_nxt     = TRAP_WORD;
            end
          end
          CMD_CHECK: begin
            if (temp_armed_r) begin
              o_strobe_nxt   = 1'b1;
              o_wv_nxt       = 1'b1;
              o_wa_nxt       = temp_addr_r;
              o_wd_nxt       = temp_word_r;
              temp_hit_nxt   = (addr_r == temp_addr_r);
              temp_armed_nxt = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      ST_STATUS: begin
        state_nxt    = ST_IDLE;
        o_strobe_nxt = 1'b1;
        o_ok_nxt     = ok_r;
        o_last_nxt   = 1'b1;
        if (cmd_r == CMD_CHECK) begin
          if (addr_r == exit_r) begin
            o_reason_nxt = REASON_EXITED;
          end else if (temp_hit_r) begin
            o_reason_nxt = REASON_STEPPED;
          end else if (slot_hit_r) begin
            o_reason_nxt = REASON_BREAK;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_idx_r     <= '0;
      p_vld_r      <= 1'b0;
      exit_r       <= 32'd0;
      temp_addr_r  <= 32'd0;
      temp_word_r  <= 16'd0;
      temp_armed_r <= 1'b0;
      o_strobe_r   <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        mode_r[i]    <= MODE_UNSET;
        written_r[i] <= 1'b0;
      end
    end else begin
      state_r      <= state_nxt;
      rd_idx_r     <= rd_idx_nxt;
      p_vld_r      <= p_vld_nxt;
      exit_r       <= exit_nxt;
      temp_addr_r  <= temp_addr_nxt;
      temp_word_r  <= temp_word_nxt;
      temp_armed_r <= temp_armed_nxt;
      o_strobe_r   <= o_strobe_nxt;
      mode_r       <= mode_nxt;
      written_r    <= written_nxt;
    end
    p_idx_r      <= p_idx_nxt;
    cmd_r        <= cmd_nxt;
    addr_r       <= addr_nxt;
    valid_r      <= valid_nxt;
    cnt_r        <= cnt_nxt;
    grp_r        <= grp_nxt;
    word_r       <= word_nxt;
    f1_r         <= f1_nxt;
    f1_idx_r     <= f1_idx_nxt;
    f2_r         <= f2_nxt;
    f2_idx_r     <= f2_idx_nxt;
    ok_r         <= ok_nxt;
    slot_hit_r   <= slot_hit_nxt;
    temp_hit_r   <= temp_hit_nxt;
    o_wv_r       <= o_wv_nxt;
    o_wa_r       <= o_wa_nxt;
    o_wd_r       <= o_wd_nxt;
    o_ok_r       <= o_ok_nxt;
    o_reason_r   <= o_reason_nxt;
    o_last_r     <= o_last_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_strobe        = o_strobe_r;
  assign out_write_valid   = o_wv_r;
  assign out_write_address = o_wa_r;
  assign out_write_data    = o_wd_r;
  assign out_ok            = o_ok_r;
  assign out_stop_reason   = o_reason_r;
  assign out_last          = o_last_r;

endmodule

FILE: hdl/btu_ram.sv
// single port write, single port registered read memory for entry fields
module btu_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: tb/sv/breakpoint_table_unit_test.sv
// self-checking testbench for breakpoint_table_unit: predicts the result words of each command
`timescale 1ns / 1ps

module breakpoint_table_unit_test
  import btu_pkg::*;
();

  localparam int ENTRIES = 32;
  localparam int POOL_SIZE = 48;
  localparam int CYCLE_LIMIT = 150000;
  localparam logic [2:0] CMD_UNKNOWN = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] address;
    logic        address_ok;
    logic [15:0] hit_count;
    logic        group_mode;
    logic [15:0] saved_word;
  } cmd_word_t;

  typedef struct packed {
    logic        write_valid;
    logic [31:0] write_address;
    logic [15:0] write_data;
    logic        ok;
    logic [1:0]  stop_reason;
    logic        last;
  } result_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_cmd = '0;
  logic [31:0] in_address = '0;
  logic        in_address_ok = 1'b0;
  logic [15:0] in_hit_count = '0;
  logic        in_group_mode = 1'b0;
  logic [15:0] in_saved_word = '0;
  logic        out_strobe;
  logic        out_write_valid;
  logic [31:0] out_write_address;
  logic [15:0] out_write_data;
  logic        out_ok;
  logic [1:0]  out_stop_reason;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  // predicted table contents
  logic [31:0] slot_addr [ENTRIES];
  logic [15:0] slot_word [ENTRIES];
  logic [15:0] slot_hits [ENTRIES];
  logic [1:0]  slot_mode [ENTRIES];
  logic [31:0] temp_addr;
  logic [15:0] temp_word;
  logic        temp_armed;
  logic [31:0] exit_addr;

  result_word_t due_words [$];
  logic [31:0]  addr_pool [POOL_SIZE];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           start_high = 1'b0;

  breakpoint_table_unit #(.ENTRIES(ENTRIES)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_address        (in_address),
    .in_address_ok     (in_address_ok),
    .in_hit_count      (in_hit_count),
    .in_group_mode     (in_group_mode),
    .in_saved_word     (in_saved_word),
    .out_strobe        (out_strobe),
    .out_write_valid   (out_write_valid),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_ok            (out_ok),
    .out_stop_reason   (out_stop_reason),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("breakpoint_table_unit test failed");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic string show_word(result_word_t w);
    return $sformatf("wv=%0b wa=%h wd=%h ok=%0b reason=%0d last=%0b", w.write_valid,
                     w.write_address, w.write_data, w.ok, w.stop_reason, w.last);
  endfunction

  function automatic void push_word(logic wv, logic [31:0] wa, logic [15:0] wd, logic ok,
                                    logic [1:0] reason, logic last);
    result_word_t w;
    w.write_valid = wv;
    w.write_address = wa;
    w.write_data = wd;
    w.ok = ok;
    w.stop_reason = reason;
    w.last = last;
    due_words.push_back(w);
  endfunction

  // updates the predicted table and queues the words one command produces
  function automatic void walk_table(cmd_word_t c);
    logic       valid;
    logic       ok;
    logic [1:0] reason;
    int         pick;
    int         i;
    valid = c.address_ok && (c.address != 32'h0);
    ok = 1'b0;
    reason = REASON_NONE;
    pick = -1;
    case (c.cmd)
      CMD_SET: begin
        if (valid) begin
          for (i = 0; i < ENTRIES; i++)
            if (pick < 0 && ((slot_mode[i] == MODE_UNSET && slot_addr[i] == 32'h0) ||
                             slot_addr[i] == c.address))
              pick = i;
          for (i = 0; i < ENTRIES; i++)
            if (pick < 0 && slot_mode[i] == MODE_UNSET) pick = i;
          if (pick >= 0) begin
            slot_mode[pick] = c.group_mode ? MODE_GROUP : MODE_SET;
            slot_addr[pick] = c.address;
            slot_word[pick] = c.saved_word;
            slot_hits[pick] = c.hit_count;
            ok = 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        for (i = 0; i < ENTRIES; i++)
          if (!ok && slot_mode[i] != MODE_UNSET && slot_addr[i] == c.address) begin
            slot_mode[i] = MODE_UNSET;
            ok = 1'b1;
          end
      end
      CMD_QUERY: begin
        if (valid)
          for (i = 0; i < ENTRIES; i++)
            if (slot_mode[i] != MODE_UNSET && slot_addr[i] == c.address) ok = 1'b1;
      end
      CMD_ARM_ALL: begin
        for (i = 0; i < ENTRIES; i++)
          if (slot_mode[i] == MODE_UNSET && slot_addr[i] != 32'h0) begin
            slot_mode[i] = MODE_SET;
            slot_hits[i] = 16'd1;
          end
      end
      CMD_SET_TEMP: begin
        temp_armed = 1'b1;
        temp_addr = c.address;
        temp_word = c.saved_word;
      end
      CMD_INSTALL: begin
        for (i = 0; i < ENTRIES; i++)
          if (slot_mode[i] != MODE_UNSET)
            push_word(1'b1, slot_addr[i], TRAP_WORD, 1'b0, REASON_NONE, 1'b0);
        if (temp_armed) push_word(1'b1, temp_addr, TRAP_WORD, 1'b0, REASON_NONE, 1'b0);
      end
      CMD_CHECK: begin
        for (i = 0; i < ENTRIES; i++)
          if (slot_mode[i] != MODE_UNSET) begin
            push_word(1'b1, slot_addr[i], slot_word[i], 1'b0, REASON_NONE, 1'b0);
            if (c.address == slot_addr[i]) begin
              reason = REASON_BREAK;
              slot_hits[i] = slot_hits[i] - 16'd1;
              if (slot_hits[i] == 16'd0) slot_mode[i] = MODE_UNSET;
            end
            if (slot_mode[i] == MODE_GROUP) slot_mode[i] = MODE_UNSET;
          end
        if (temp_armed) begin
          push_word(1'b1, temp_addr, temp_word, 1'b0, REASON_NONE, 1'b0);
          if (c.address == temp_addr) reason = REASON_STEPPED;
          temp_armed = 1'b0;
        end
        if (c.address == exit_addr) reason = REASON_EXITED;
      end
      default: ;
    endcase
    push_word(1'b0, 32'h0, 16'h0, ok, reason, 1'b1);
  endfunction

  always @(posedge clk) begin : check_words
    result_word_t seen;
    result_word_t want;
    if (rst_n && out_strobe === 1'b1) begin
      seen.write_valid = out_write_valid;
      seen.write_address = out_write_address;
      seen.write_data = out_write_data;
      seen.ok = out_ok;
      seen.stop_reason = out_stop_reason;
      seen.last = out_last;
      if (due_words.size() == 0) begin
        report_mismatch({"word with none due: ", show_word(seen)});
      end else begin
        want = due_words.pop_front();
        if (seen.write_valid !== want.write_valid || seen.write_address !== want.write_address ||
            seen.write_data !== want.write_data || seen.ok !== want.ok ||
            seen.stop_reason !== want.stop_reason || seen.last !== want.last)
          report_mismatch({"got ", show_word(seen), " want ", show_word(want)});
      end
    end
  end

  task automatic drop_start();
    if (start_high) begin
      start <= 1'b0;
      start_high = 1'b0;
    end
  endtask

  task automatic issue(cmd_word_t c);
    start <= 1'b1;
    start_high = 1'b1;
    in_cmd <= c.cmd;
    in_address <= c.address;
    in_address_ok <= c.address_ok;
    in_hit_count <= c.hit_count;
    in_group_mode <= c.group_mode;
    in_saved_word <= c.saved_word;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    walk_table(c);
  endtask

  task automatic issue_fields(logic [2:0] cmd, logic [31:0] address, logic address_ok,
                              logic [15:0] hit_count, logic group_mode, logic [15:0] word);
    cmd_word_t c;
    c.cmd = cmd;
    c.address = address;
    c.address_ok = address_ok;
    c.hit_count = hit_count;
    c.group_mode = group_mode;
    c.saved_word = word;
    issue(c);
  endtask

  task automatic pause_sender(int cycles);
    drop_start();
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_not_busy();
    drop_start();
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic wait_drained();
    drop_start();
    while (due_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_exit(logic [31:0] value);
    wait_drained();
    wait_not_busy();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    exit_addr = value;
  endtask

  function automatic logic [31:0] pick_address();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h0;
    if (r < 3) return $urandom;
    return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic cmd_word_t random_command();
    cmd_word_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) c.cmd = CMD_SET;
    else if (r < 45) c.cmd = CMD_CLEAR;
    else if (r < 55) c.cmd = CMD_QUERY;
    else if (r < 59) c.cmd = CMD_ARM_ALL;
    else if (r < 69) c.cmd = CMD_SET_TEMP;
    else if (r < 79) c.cmd = CMD_INSTALL;
    else if (r < 98) c.cmd = CMD_CHECK;
    else c.cmd = CMD_UNKNOWN;
    c.address = pick_address();
    if (c.cmd == CMD_CHECK) begin
      r = $urandom_range(0, 9);
      if (r < 2) c.address = temp_addr;
      else if (r == 2) c.address = exit_addr;
    end
    c.address_ok = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 4) < 3) c.hit_count = 16'($urandom_range(0, 3));
    else c.hit_count = 16'($urandom_range(0, 65535));
    c.group_mode = ($urandom_range(0, 9) < 3);
    c.saved_word = 16'($urandom_range(0, 65535));
    return c;
  endfunction

  task automatic test_rejects();
    issue_fields(CMD_QUERY, 32'hffff_ffff, 1'b1, 16'h0, 1'b0, 16'h0);
    issue_fields(CMD_SET, 32'h0, 1'b1, 16'h1, 1'b0, 16'h1111);
    issue_fields(CMD_SET, 32'hffff_ffff, 1'b0, 16'h1, 1'b0, 16'h2222);
    issue_fields(CMD_QUERY, 32'h0, 1'b1, 16'h0, 1'b0, 16'h0);
  endtask

  task automatic test_set_and_install();
    issue_fields(CMD_SET, 32'hffff_ffff, 1'b1, 16'h0, 1'b0, 16'hffff);
    issue_fields(CMD_SET, 32'h0000_0001, 1'b1, 16'h2, 1'b1, 16'h0000);
    issue_fields(CMD_SET, 32'h8000_0000, 1'b1, 16'hffff, 1'b0, 16'h5a5a);
    issue_fields(CMD_SET, 32'hffff_ffff, 1'b1, 16'h0, 1'b0, 16'ha5a5);
    issue_fields(CMD_SET_TEMP, 32'h1234_5678, 1'b0, 16'h0, 1'b0, 16'hbeef);
    issue_fields(CMD_INSTALL, 32'h0, 1'b0, 16'h0, 1'b0, 16'h0);
  endtask

  task automatic test_zero_count_hit();
    issue_fields(CMD_CHECK, 32'hffff_ffff, 1'b1, 16'h0, 1'b0, 16'h0);
  endtask

  task automatic test_clear_and_arm();
    issue_fields(CMD_QUERY, 32'h0000_0001, 1'b1, 16'h0, 1'b0, 16'h0);
    issue_fields(CMD_QUERY, 32'h8000_0000, 1'b1, 16'h0, 1'b0, 16'h0);
    issue_fields(CMD_CLEAR, 32'hffff_ffff, 1'b0, 16'h0, 1'b0, 16'h0);
    issue_fields(CMD_CLEAR, 32'hffff_ffff, 1'b1, 16'h0, 1'b0, 16'h0);
    issue_fields(CMD_ARM_ALL, 32'h0, 1'b0, 16'h0, 1'b0, 16'h0);
    issue_fields(CMD_INSTALL, 32'h0, 1'b0, 16'h0, 1'b0, 16'h0);
  endtask

  task automatic test_stop_reasons();
    issue_fields(CMD_SET_TEMP, 32'h1234_5678, 1'b1, 16'h0, 1'b0, 16'h7777);
    issue_fields(CMD_CHECK, 32'h1234_5678, 1'b1, 16'h0, 1'b0, 16'h0);
    write_exit(32'h8000_0000);
    issue_fields(CMD_SET_TEMP, 32'h8000_0000, 1'b1, 16'h0, 1'b0, 16'h3c3c);
    issue_fields(CMD_CHECK, 32'h8000_0000, 1'b1, 16'h0, 1'b0, 16'h0);
    issue_fields(CMD_CHECK, 32'h0000_0001, 1'b1, 16'h0, 1'b0, 16'h0);
    issue_fields(CMD_UNKNOWN, 32'hffff_ffff, 1'b1, 16'hffff, 1'b1, 16'hffff);
  endtask

  task automatic test_random_traffic(int count, bit with_idle);
    cmd_word_t c;
    for (int n = 0; n < count; n++) begin
      c = random_command();
      if (with_idle && $urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 1) wait_not_busy();
        pause_sender($urandom_range(1, 8));
      end
      issue(c);
    end
  endtask

  task automatic test_table_full();
    for (int n = 0; n < 40; n++)
      issue_fields(CMD_SET, addr_pool[n], 1'b1, 16'($urandom_range(1, 4)),
                   ($urandom_range(0, 4) == 0), 16'($urandom_range(0, 65535)));
    issue_fields(CMD_INSTALL, 32'h0, 1'b0, 16'h0, 1'b0, 16'h0);
    issue_fields(CMD_CHECK, addr_pool[$urandom_range(0, 39)], 1'b1, 16'h0, 1'b0, 16'h0);
  endtask

  task automatic test_sender_pause();
    test_random_traffic(10, 1'b1);
    wait_drained();
    test_random_traffic(10, 1'b1);
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      slot_addr[i] = 32'h0;
      slot_word[i] = 16'h0;
      slot_hits[i] = 16'h0;
      slot_mode[i] = MODE_UNSET;
    end
    temp_addr = 32'h0;
    temp_word = 16'h0;
    temp_armed = 1'b0;
    exit_addr = 32'h0;
    addr_pool[0] = 32'hffff_ffff;
    addr_pool[1] = 32'h0000_0001;
    for (int i = 2; i < POOL_SIZE; i++) begin
      addr_pool[i] = $urandom;
      if (addr_pool[i] == 32'h0) addr_pool[i] = 32'h0000_0100 + i;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    write_exit(32'h0000_0100);
    test_rejects();
    test_set_and_install();
    test_zero_count_hit();
    test_clear_and_arm();
    test_stop_reasons();
    write_exit(32'hffff_ffff);
    test_random_traffic(50, 1'b1);
    test_table_full();
    write_exit(32'h0);
    test_random_traffic(50, 1'b1);
    write_exit($urandom);
    test_random_traffic(50, 1'b1);
    write_exit(addr_pool[5]);
    test_sender_pause();
    test_random_traffic(40, 1'b0);
    wait_drained();
    repeat (ENTRIES + 8) @(posedge clk);
    if (mismatch_count == 0 && due_words.size() == 0) begin
      $display("breakpoint_table_unit test passed");
    end else begin
      $display("breakpoint_table_unit test failed");
    end
    $finish;
  end

endmodule
